>>> rtl/core/knn_pkg.sv
package knn_pkg;

  localparam int K_MAX      = 16;
  localparam int DIM_MAX    = 256;
  localparam int COORD_BITS = 16;

  localparam int COORD_W  = 16;
  localparam int ID_W     = 32;
  localparam int DIST_W   = 40;
  localparam int RANK_W   = 4;
  localparam int KCFG_W   = 5;
  localparam int DCFG_W   = 9;

  localparam int K_W    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int FILL_W = $clog2(K_MAX + 1);
  localparam int CNT_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int DIMS_W = $clog2(DIM_MAX + 1);

  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DCFG_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION_COUNT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
    logic              last;
  } cand_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  function automatic logic [FILL_W-1:0] eff_k(input logic [KCFG_W-1:0] nc);
    logic [FILL_W-1:0] k;
    if (nc == '0) begin
      k = FILL_W'(1);
    end else if (int'(nc) > K_MAX) begin
      k = FILL_W'(K_MAX);
    end else begin
      k = FILL_W'(nc);
    end
    return k;
  endfunction

  function automatic logic [DIMS_W-1:0] eff_dims(input logic [DCFG_W-1:0] dc);
    logic [DIMS_W-1:0] d;
    if (dc == '0) begin
      d = DIMS_W'(1);
    end else if (int'(dc) > DIM_MAX) begin
      d = DIMS_W'(DIM_MAX);
    end else begin
      d = DIMS_W'(dc);
    end
    return d;
  endfunction

endpackage

>>> rtl/core/knn_front.sv
module knn_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [knn_pkg::DIMS_W-1:0]      dims,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [knn_pkg::COORD_W-1:0] query_coord,
  input  logic signed [knn_pkg::COORD_W-1:0] cand_coord,
  input  logic [knn_pkg::ID_W-1:0]        cand_id,
  input  logic                            last_cand,
  output logic                            cand_valid,
  input  logic                            cand_ready,
  output knn_pkg::cand_t                  cand
);
  import knn_pkg::*;

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [SQ_W-1:0]         sq;
  logic                    done_now;
  logic                    accepted;
  logic                    s1_go;
  logic [SUM_W-1:0]        sum;
  logic [DIST_W-1:0]       sum_sat;

  logic [CNT_W-1:0]  coord_counter;
  logic [DIST_W-1:0] dist_accum;
  logic              s1_valid;
  logic              s1_done;
  logic              s1_last;
  logic [ID_W-1:0]   s1_id;
  logic [SQ_W-1:0]   s1_sq;

  always_comb begin
    diff = MAG_W'($signed(query_coord[COORD_BITS-1:0]))
         - MAG_W'($signed(cand_coord[COORD_BITS-1:0]));
    mag  = diff[MAG_W-1] ? $unsigned(-diff) : $unsigned(diff);
    sq   = SQ_W'(mag) * SQ_W'(mag);
    done_now = (DIMS_W'(coord_counter) + DIMS_W'(1)) >= dims;
  end

  assign s1_go      = !s1_done || cand_ready;
  assign in_ready   = !s1_valid || s1_go;
  assign accepted   = in_valid && in_ready;
  assign cand_valid = s1_valid && s1_done;

  always_comb begin
    sum     = SUM_W'(dist_accum) + SUM_W'(s1_sq);
    sum_sat = (sum >= SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    cand.id      = s1_id;
    cand.sq_dist = sum_sat;
    cand.last    = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      coord_counter <= '0;
      dist_accum    <= '0;
    end else begin
      if (accepted) begin
        s1_valid      <= 1'b1;
        coord_counter <= done_now ? '0 : coord_counter + CNT_W'(1);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_go) begin
        dist_accum <= s1_done ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      s1_sq   <= sq;
      s1_done <= done_now;
      s1_id   <= cand_id;
      s1_last <= last_cand;
    end
  end

endmodule

>>> rtl/core/knn_queue.sv
module knn_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  knn_pkg::cand_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output knn_pkg::cand_t out_data
);
  import knn_pkg::*;

  cand_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      priority if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

>>> rtl/core/knn_back.sv
module knn_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [knn_pkg::FILL_W-1:0]  k,
  input  logic                        cand_valid,
  output logic                        cand_ready,
  input  knn_pkg::cand_t              cand,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [knn_pkg::RANK_W-1:0]  rank,
  output logic [knn_pkg::ID_W-1:0]    neighbor_id,
  output logic [knn_pkg::DIST_W-1:0]  neighbor_dist,
  output logic                        last
);
  import knn_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [DIST_W-1:0] list_dist [K_MAX];
  logic [ID_W-1:0]   list_id   [K_MAX];
  logic [FILL_W-1:0] fill;
  logic [K_W-1:0]    idx;

  logic [K_MAX-1:0]  lt;
  logic [K_MAX-1:0]  below;
  logic [FILL_W-1:0] fill_c;
  logic              full;
  logic              admit;
  logic              pop;
  logic              out_free;
  logic              emit_load;
  logic              entry_last;

  always_comb begin
    fill_c = (fill > k) ? k : fill;
    full   = fill_c == k;
    for (int i = 0; i < K_MAX; i++) begin
      lt[i]    = cand.sq_dist < list_dist[i];
      below[i] = (FILL_W'(i) < fill_c) && !lt[i];
    end
    admit      = !full || lt[K_W'(k - FILL_W'(1))];
    entry_last = (FILL_W'(idx) + FILL_W'(1)) == fill;
    out_free   = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cand_valid && cand.last) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free && entry_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cand_ready = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      BK_IDLE: cand_ready = 1'b1;
      BK_EMIT: emit_load  = out_free;
      default: begin
        cand_ready = 1'b0;
        emit_load  = 1'b0;
      end
    endcase
  end

  assign pop = cand_valid && cand_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      fill      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        fill <= full ? fill_c : fill_c + FILL_W'(1);
      end
      if (emit_load) begin
        idx <= entry_last ? '0 : idx + K_W'(1);
        if (entry_last) begin
          fill <= '0;
        end
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && admit) begin
      if (!below[0]) begin
        list_dist[0] <= cand.sq_dist;
        list_id[0]   <= cand.id;
      end
      for (int i = 1; i < K_MAX; i++) begin
        if (!below[i]) begin
          if (below[i-1]) begin
            list_dist[i] <= cand.sq_dist;
            list_id[i]   <= cand.id;
          end else begin
            list_dist[i] <= list_dist[i-1];
            list_id[i]   <= list_id[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      rank          <= RANK_W'(idx);
      neighbor_id   <= list_id[idx];
      neighbor_dist <= list_dist[idx];
      last          <= entry_last;
    end
  end

endmodule

>>> rtl/core/knn_topk_distance_select.sv
// channel | signals                                          | transaction
// in      | in_valid in_ready query_coord cand_coord cand_id | one coordinate pair
//         | last_cand                                        |
// out     | out_valid out_ready rank neighbor_id             | one list entry
//         | neighbor_dist last                               |
// cfg     | cfg_valid cfg_ready cfg_index cfg_data           | one register write
//
// The front takes one coordinate pair per cycle while in_ready is high: squarer, then accumulator stage.
// A finished candidate enters the sorted list by a parallel compare and shift.
// A list of n entries drains at one entry per cycle while out_ready is high; the 4-entry candidate queue
// keeps the front running meanwhile, and it stalls only once that queue is full.
// Reset clears counters, accumulator and list fill; k resets to 4, dimensions to 2.
// out_ready low while out_valid is high holds the output register and the list drain.
module knn_topk_distance_select (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [knn_pkg::COORD_W-1:0] query_coord,
  input  logic signed [knn_pkg::COORD_W-1:0] cand_coord,
  input  logic [knn_pkg::ID_W-1:0]          cand_id,
  input  logic                              last_cand,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [knn_pkg::RANK_W-1:0]        rank,
  output logic [knn_pkg::ID_W-1:0]          neighbor_id,
  output logic [knn_pkg::DIST_W-1:0]        neighbor_dist,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [knn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import knn_pkg::*;

  logic [KCFG_W-1:0] neighbor_count;
  logic [DCFG_W-1:0] dimension_count;
  logic [DIMS_W-1:0] dims;
  logic [FILL_W-1:0] k;

  logic  fq_valid;
  logic  fq_ready;
  cand_t fq_data;
  logic  qb_valid;
  logic  qb_ready;
  cand_t qb_data;

  assign cfg_ready = 1'b1;
  assign dims      = eff_dims(dimension_count);
  assign k         = eff_k(neighbor_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count  <= KCFG_W'(4);
      dimension_count <= DCFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NEIGHBOR_COUNT:  neighbor_count  <= cfg_data[KCFG_W-1:0];
        CFG_DIMENSION_COUNT: dimension_count <= cfg_data[DCFG_W-1:0];
        default: ;
      endcase
    end
  end

  knn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .dims        (dims),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .query_coord (query_coord),
    .cand_coord  (cand_coord),
    .cand_id     (cand_id),
    .last_cand   (last_cand),
    .cand_valid  (fq_valid),
    .cand_ready  (fq_ready),
    .cand        (fq_data)
  );

  knn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  knn_back u_back (
    .clk           (clk),
    .rst           (rst),
    .k             (k),
    .cand_valid    (qb_valid),
    .cand_ready    (qb_ready),
    .cand          (qb_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rank          (rank),
    .neighbor_id   (neighbor_id),
    .neighbor_dist (neighbor_dist),
    .last          (last)
  );

endmodule

>>> rtl/core/knn_checker.sv
module knn_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [knn_pkg::RANK_W-1:0]       rank,
  input logic [knn_pkg::ID_W-1:0]         neighbor_id,
  input logic [knn_pkg::DIST_W-1:0]       neighbor_dist,
  input logic                             last
);
  import knn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(neighbor_id)
      && $stable(neighbor_dist) && $stable(rank) && $stable(last))
    else $error("output changed while stalled");

  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && rank == $past(rank) + RANK_W'(1))
    else $error("list drain skipped a rank");

  a_dist_sorted: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> neighbor_dist >= $past(neighbor_dist))
    else $error("emitted list not in ascending distance");

  a_list_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || rank == '0)
    else $error("new list did not start at rank zero");

endmodule

bind knn_topk_distance_select knn_checker u_knn_checker (.*);
